### hw/rtl/upe_pkg.sv
// shared types, constants and helpers for the utf-8 path json escaper
package upe_pkg;

   // register reset values
   localparam logic [15:0] MAX_LENGTH_RST      = 16'd4096;
   localparam logic [7:0]  MAX_SEGMENTS_RST    = 8'd32;
   localparam logic [15:0] MAX_CODE_POINTS_RST = 16'd1024;
   localparam logic [15:0] OUTPUT_LIMIT_RST    = 16'd4096;

   // depth of the queue between front and back
   localparam int UPE_QUEUE_DEPTH = 4;

   // register indexes on the csr port
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LENGTH      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_SEGMENTS    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_CODE_POINTS = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTPUT_LIMIT    = 2'd3;
   localparam int CSR_DATA_W = 16;

   // character codes
   localparam logic [7:0] CHAR_SLASH  = 8'h2f;
   localparam logic [7:0] CHAR_DOT    = 8'h2e;
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5c;
   localparam logic [7:0] CHAR_U      = 8'h75;
   localparam logic [7:0] CHAR_DEL    = 8'h7f;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;

   // code point limits
   localparam logic [20:0] CP_MAX     = 21'h10ffff;
   localparam logic [20:0] CP_SUR_LO  = 21'h00d800;
   localparam logic [20:0] CP_SUR_HI  = 21'h00dfff;
   localparam logic [20:0] CP_PLANE1  = 21'h010000;
   localparam logic [5:0]  SUR_HIGH_TAG = 6'b110110;
   localparam logic [5:0]  SUR_LOW_TAG  = 6'b110111;

   // headroom kept below the output limit before each character
   localparam logic [16:0] OUT_HEADROOM = 17'd13;

   // how one character expands on the output
   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_ASCII,
      KIND_QUOTE,
      KIND_BMP,
      KIND_PAIR
   } upe_kind_type;

   // configuration registers
   typedef struct packed {
      logic [15:0] max_length;
      logic [7:0]  max_segments;
      logic [15:0] max_code_points;
      logic [15:0] output_limit;
   } upe_cfg_type;

   // one queue entry: an escaped character and/or the closing status
   typedef struct packed {
      upe_kind_type kind;
      logic [15:0]  unit_hi;
      logic [15:0]  unit_lo;
      logic         has_status;
      logic         status;
   } upe_job_type;

   // number of bytes a character kind expands to
   function automatic logic [3:0] kind_bytes(input upe_kind_type kind);
      logic [3:0] n;
      unique case (kind)
         KIND_NONE:  n = 4'd0;
         KIND_ASCII: n = 4'd1;
         KIND_QUOTE: n = 4'd2;
         KIND_BMP:   n = 4'd6;
         KIND_PAIR:  n = 4'd12;
         default:    n = 4'd0;
      endcase
      return n;
   endfunction

   // lower-case hex digit
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] c;
      if (nib < 4'd10) begin
         c = 8'h30 + {4'h0, nib};
      end else begin
         c = 8'h57 + {4'h0, nib};
      end
      return c;
   endfunction

   // smallest legal code point for each sequence length
   function automatic logic [20:0] min_by_class(input logic [1:0] cls);
      logic [20:0] m;
      unique case (cls)
         2'd0:    m = 21'h0;
         2'd1:    m = 21'h80;
         2'd2:    m = 21'h800;
         default: m = 21'h10000;
      endcase
      return m;
   endfunction

   // empty, dot or dot-dot segment
   function automatic logic segment_bad(input logic [1:0] len, input logic all_dots);
      return (len == 2'd0) || (all_dots && (len <= 2'd2));
   endfunction

endpackage

### hw/rtl/upe_front.sv
// front: decodes utf-8, checks path rules and limits, queues escape jobs
module upe_front
   import upe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  upe_cfg_type cfg,
   input  logic        req_valid,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   output logic        req_stall,
   input  logic        q_full,
   output logic        q_push,
   output upe_job_type q_data
);

   logic [20:0] code_point_acc_ff, code_point_acc_in;
   logic [1:0]  pending_ff, pending_in;
   logic [1:0]  min_class_ff, min_class_in;
   logic [15:0] byte_count_ff, byte_count_in;
   logic [1:0]  seg_len_ff, seg_len_in;
   logic        all_dots_ff, all_dots_in;
   logic [7:0]  seg_count_ff, seg_count_in;
   logic [15:0] cp_count_ff, cp_count_in;
   logic [15:0] out_count_ff, out_count_in;
   logic        error_ff, error_in;

   logic        accept;
   logic        err;
   logic        ready;
   logic [20:0] cp;
   logic [20:0] pair_v;
   logic [16:0] out_sum;
   upe_kind_type kind;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign out_sum   = {1'b0, out_count_ff} + OUT_HEADROOM;
   assign pair_v    = cp - CP_PLANE1;

   // per-beat decode and checks
   always_comb begin
      code_point_acc_in = code_point_acc_ff;
      pending_in        = pending_ff;
      min_class_in      = min_class_ff;
      byte_count_in     = byte_count_ff;
      seg_len_in        = seg_len_ff;
      all_dots_in       = all_dots_ff;
      seg_count_in      = seg_count_ff;
      cp_count_in       = cp_count_ff;
      out_count_in      = out_count_ff;
      error_in          = error_ff;
      err               = 1'b0;
      ready             = 1'b0;
      cp                = '0;
      kind              = KIND_NONE;

      if (!error_ff) begin
         // length limit
         if (byte_count_ff >= cfg.max_length) begin
            err = 1'b1;
         end else begin
            byte_count_in = byte_count_ff + 16'd1;
         end

         // segment rules
         if (req_in_byte == CHAR_SLASH) begin
            if (segment_bad(seg_len_ff, all_dots_ff)) begin
               err = 1'b1;
            end
            if (seg_count_ff >= cfg.max_segments) begin
               err = 1'b1;
            end else begin
               seg_count_in = seg_count_ff + 8'd1;
            end
            seg_len_in  = 2'd0;
            all_dots_in = 1'b1;
         end else begin
            if (seg_len_ff != 2'd3) begin
               seg_len_in = seg_len_ff + 2'd1;
            end
            if (req_in_byte != CHAR_DOT) begin
               all_dots_in = 1'b0;
            end
         end

         // utf-8 decode
         if (pending_ff == 2'd0) begin
            if (!req_in_byte[7]) begin
               cp           = {13'd0, req_in_byte};
               min_class_in = 2'd0;
               ready        = 1'b1;
            end else if (req_in_byte >= 8'hc2 && req_in_byte <= 8'hdf) begin
               code_point_acc_in = {16'd0, req_in_byte[4:0]};
               pending_in        = 2'd1;
               min_class_in      = 2'd1;
            end else if (req_in_byte >= 8'he0 && req_in_byte <= 8'hef) begin
               code_point_acc_in = {17'd0, req_in_byte[3:0]};
               pending_in        = 2'd2;
               min_class_in      = 2'd2;
            end else if (req_in_byte >= 8'hf0 && req_in_byte <= 8'hf4) begin
               code_point_acc_in = {18'd0, req_in_byte[2:0]};
               pending_in        = 2'd3;
               min_class_in      = 2'd3;
            end else begin
               err = 1'b1;
            end
         end else if (req_in_byte[7:6] != 2'b10) begin
            err = 1'b1;
         end else begin
            code_point_acc_in = {code_point_acc_ff[14:0], req_in_byte[5:0]};
            pending_in        = pending_ff - 2'd1;
            if (pending_ff == 2'd1) begin
               cp    = {code_point_acc_ff[14:0], req_in_byte[5:0]};
               ready = 1'b1;
            end
         end

         // end of path with open sequence or bad final segment
         if (req_in_last && (pending_in != 2'd0 || segment_bad(seg_len_in, all_dots_in))) begin
            err = 1'b1;
         end

         // character checks and expansion
         if (!err && ready) begin
            if (cp < min_by_class(min_class_in) || cp > CP_MAX ||
                (cp >= CP_SUR_LO && cp <= CP_SUR_HI) || cp < {13'd0, CHAR_SPACE} ||
                cp == {13'd0, CHAR_DEL} || cp == {13'd0, CHAR_BSLASH} ||
                cp_count_ff >= cfg.max_code_points ||
                out_sum >= {1'b0, cfg.output_limit}) begin
               err = 1'b1;
            end else begin
               cp_count_in = cp_count_ff + 16'd1;
               if (cp == {13'd0, CHAR_QUOTE}) begin
                  kind = KIND_QUOTE;
               end else if (cp < 21'h80) begin
                  kind = KIND_ASCII;
               end else if (cp < CP_PLANE1) begin
                  kind = KIND_BMP;
               end else begin
                  kind = KIND_PAIR;
               end
               out_count_in = out_count_ff + {12'd0, kind_bytes(kind)};
            end
         end

         if (err) begin
            error_in = 1'b1;
            kind     = KIND_NONE;
         end
      end
   end

   // queue entry
   always_comb begin
      q_data.kind       = kind;
      q_data.has_status = req_in_last;
      q_data.status     = error_in;
      if (kind == KIND_PAIR) begin
         q_data.unit_hi = {SUR_HIGH_TAG, pair_v[19:10]};
         q_data.unit_lo = {SUR_LOW_TAG, pair_v[9:0]};
      end else begin
         q_data.unit_hi = cp[15:0];
         q_data.unit_lo = cp[15:0];
      end
   end

   assign q_push = accept && (kind != KIND_NONE || req_in_last);

   // path state, cleared after the final beat
   always_ff @(posedge clock) begin
      if (reset || (accept && req_in_last)) begin
         code_point_acc_ff <= '0;
         pending_ff        <= '0;
         min_class_ff      <= '0;
         byte_count_ff     <= '0;
         seg_len_ff        <= '0;
         all_dots_ff       <= 1'b1;
         seg_count_ff      <= 8'd1;
         cp_count_ff       <= '0;
         out_count_ff      <= '0;
         error_ff          <= 1'b0;
      end else if (accept) begin
         code_point_acc_ff <= code_point_acc_in;
         pending_ff        <= pending_in;
         min_class_ff      <= min_class_in;
         byte_count_ff     <= byte_count_in;
         seg_len_ff        <= seg_len_in;
         all_dots_ff       <= all_dots_in;
         seg_count_ff      <= seg_count_in;
         cp_count_ff       <= cp_count_in;
         out_count_ff      <= out_count_in;
         error_ff          <= error_in;
      end
   end

endmodule

### hw/rtl/upe_queue.sv
// small register queue between front and back
module upe_queue
   import upe_pkg::*;
#(
   parameter int DEPTH = UPE_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  upe_job_type push_data,
   input  logic        pop,
   output upe_job_type head,
   output logic        not_empty,
   output logic        full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   upe_job_type           entries_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   assign head      = entries_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CNT_FULL);

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hw/rtl/upe_back.sv
// back: expands queued jobs into escaped bytes and status beats
module upe_back
   import upe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  upe_job_type q_head,
   input  logic        q_not_empty,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_out_last,
   output logic        rsp_status
);

   upe_job_type cur_ff;
   logic        busy_ff, busy_in;
   logic [3:0]  idx_ff, idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff;
   logic        rsp_byte_valid_ff;
   logic        rsp_last_ff;
   logic        rsp_status_ff;

   logic        out_free;
   logic        advance;
   logic        last_beat;
   logic [3:0]  n_bytes;
   logic        is_data;
   logic [15:0] unit;
   logic [3:0]  pos;
   logic [7:0]  beat_byte;

   assign n_bytes   = kind_bytes(cur_ff.kind);
   assign is_data   = (idx_ff < n_bytes);
   assign last_beat = cur_ff.has_status ? (idx_ff == n_bytes) : (idx_ff == n_bytes - 4'd1);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = busy_ff && out_free;
   assign q_pop     = q_not_empty && (!busy_ff || (advance && last_beat));

   // which half of a surrogate pair and where in the escape
   assign unit = (idx_ff >= 4'd6) ? cur_ff.unit_lo : cur_ff.unit_hi;
   assign pos  = (idx_ff >= 4'd6) ? idx_ff - 4'd6 : idx_ff;

   // byte for the current beat
   always_comb begin
      beat_byte = 8'h00;
      if (is_data) begin
         unique case (cur_ff.kind) inside
            KIND_ASCII: beat_byte = cur_ff.unit_hi[7:0];
            KIND_QUOTE: beat_byte = (idx_ff == 4'd0) ? CHAR_BSLASH : CHAR_QUOTE;
            KIND_BMP, KIND_PAIR: begin
               case (pos[2:0])
                  3'd0:    beat_byte = CHAR_BSLASH;
                  3'd1:    beat_byte = CHAR_U;
                  3'd2:    beat_byte = hex_char(unit[15:12]);
                  3'd3:    beat_byte = hex_char(unit[11:8]);
                  3'd4:    beat_byte = hex_char(unit[7:4]);
                  default: beat_byte = hex_char(unit[3:0]);
               endcase
            end
            default:    beat_byte = 8'h00;
         endcase
      end
   end

   // sequencing of the current job
   always_comb begin
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
      if (q_pop) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (advance && last_beat) begin
         busy_in = 1'b0;
      end else if (advance) begin
         idx_in = idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // job and output payload
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_head;
      end
      if (advance) begin
         rsp_byte_ff       <= beat_byte;
         rsp_byte_valid_ff <= is_data;
         rsp_last_ff       <= !is_data;
         rsp_status_ff     <= !is_data && cur_ff.status;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_byte_valid = rsp_byte_valid_ff;
   assign rsp_out_last   = rsp_last_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

### hw/rtl/utf8_path_json_escaper.sv
// top level of the utf-8 path to ascii json string escaper
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_in_byte, req_in_last
//   rsp      out        rsp_valid/rsp_stall   rsp_out_byte, rsp_byte_valid,
//                                             rsp_out_last, rsp_status
//   csr      in         csr_we                csr_index, csr_wdata
//
// the front takes one byte a cycle while the job queue has room and queues one job per
// character, the final byte's job also carrying the status; the back sends one beat a
// cycle from its output register while rsp is not stalled, so a character becomes 1, 2,
// 6 or 12 data beats and the status one more. a byte passes the queue, the back's job
// register and the output register. req_stall rises while the job queue is full; a
// stalled rsp holds its register. reset is synchronous and restores the defaults.
module utf8_path_json_escaper
   import upe_pkg::*;
#(
   parameter int QUEUE_DEPTH = UPE_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_in_byte,
   input  logic                   req_in_last,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_byte_valid,
   output logic                   rsp_out_last,
   output logic                   rsp_status,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   upe_cfg_type cfg_ff;
   upe_job_type push_data;
   upe_job_type head;
   logic        push;
   logic        pop;
   logic        not_empty;
   logic        full;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_length      <= MAX_LENGTH_RST;
         cfg_ff.max_segments    <= MAX_SEGMENTS_RST;
         cfg_ff.max_code_points <= MAX_CODE_POINTS_RST;
         cfg_ff.output_limit    <= OUTPUT_LIMIT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_LENGTH:      cfg_ff.max_length      <= csr_wdata;
            CSR_MAX_SEGMENTS:    cfg_ff.max_segments    <= csr_wdata[7:0];
            CSR_MAX_CODE_POINTS: cfg_ff.max_code_points <= csr_wdata;
            CSR_OUTPUT_LIMIT:    cfg_ff.output_limit    <= csr_wdata;
            default:             cfg_ff                 <= cfg_ff;
         endcase
      end
   end

   upe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .req_stall   (req_stall),
      .q_full      (full),
      .q_push      (push),
      .q_data      (push_data)
   );

   upe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .full      (full)
   );

   upe_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_head         (head),
      .q_not_empty    (not_empty),
      .q_pop          (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_out_last   (rsp_out_last),
      .rsp_status     (rsp_status)
   );

endmodule

### hw/rtl/upe_checker.sv
// port-level checks for the escaper, bound to the top level
module upe_checker
   import upe_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic [7:0]             req_in_byte,
   input logic                   req_in_last,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [7:0]             rsp_out_byte,
   input logic                   rsp_byte_valid,
   input logic                   rsp_out_last,
   input logic                   rsp_status
);

   // a stalled request beat stays put
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_in_byte) && $stable(req_in_last))
      else $error("req beat changed while stalled");

   // a stalled beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) &&
         $stable(rsp_byte_valid) && $stable(rsp_out_last) && $stable(rsp_status))
      else $error("rsp beat changed while stalled");

   // status beat closes the path and carries no byte
   a_status_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_out_last && rsp_out_byte == 8'h00)
      else $error("malformed status beat");

   // data beats carry no status
   a_data_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_valid |-> !rsp_out_last && !rsp_status)
      else $error("data beat flagged as status");

   // escaped output is printable ascii only
   a_data_ascii: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_valid |-> !rsp_out_byte[7] && rsp_out_byte >= CHAR_SPACE &&
         rsp_out_byte != CHAR_DEL)
      else $error("data byte outside printable ascii");

endmodule

bind utf8_path_json_escaper upe_checker u_upe_checker (.*);
